### sv/dp_pkg.sv
// ----------------------------------------------------------------------------
// dp_pkg: shared definitions for the digit persistence block
// Widths, limits and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package dp_pkg;

	localparam int NUM_W       = 64;
	localparam int DIGIT_W     = 4;
	localparam int DIGITS      = 20;
	localparam int BCD_W       = DIGITS * DIGIT_W;
	localparam int BIT_CNT_W   = $clog2(NUM_W);
	localparam int STEPS_W     = 4;
	localparam int OUT_TDATA_W = 8;

	localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};
	localparam logic [NUM_W-1:0]   RADIX     = NUM_W'(10);

	localparam logic [DIGIT_W-1:0] DD_THRESH = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] DD_ADJUST = DIGIT_W'(3);

	typedef struct packed {
		logic load;        // take a new input word
		logic start_conv;  // clear the BCD register and seed the accumulator
		logic conv_step;   // one shift-add-3 step of the binary to BCD conversion
		logic acc_step;    // fold one decimal digit into the accumulator
		logic out_load;    // copy the step count into the output register
	} cmd_t;

	typedef struct packed {
		logic done;        // value below ten or count saturated
		logic conv_last;   // last bit of the conversion is being shifted in
		logic acc_last;    // last nonzero-leading digit is being folded in
	} sts_t;

endpackage

### sv/digit_persistence.sv
// ----------------------------------------------------------------------------
// digit_persistence: additive or multiplicative decimal digit persistence
// Counts how often a 64-bit value is replaced by its digit sum or digit
// product until it falls below ten or the four-bit count saturates.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                         Contents (low bit up)
// s_*      in   s_tvalid s_tready s_tdata s_tuser  tdata: number[63:0]; tuser: kind
// m_*      out  m_tvalid m_tready m_tdata         tdata: steps[3:0], zeros [7:4]
//
// One word is worked on at a time. Each round is a check, a bit-serial binary
// to BCD conversion of all 64 bits and one accumulation step per decimal digit
// of the value (2 to 20).
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled result holds in the output register and the next word is taken
// once it has been moved there.
// ----------------------------------------------------------------------------
module digit_persistence (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dp_pkg::NUM_W-1:0]        s_tdata,   // number[63:0]
	input  logic                            s_tuser,   // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dp_pkg::OUT_TDATA_W-1:0]  m_tdata    // steps[3:0], zero pad
);

	dp_pkg::cmd_t               cmd;
	dp_pkg::sts_t               sts;
	logic [dp_pkg::STEPS_W-1:0] steps;

	dp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_tuser),
		.in_number (s_tdata),
		.steps     (steps)
	);

	assign m_tdata = {{(dp_pkg::OUT_TDATA_W-dp_pkg::STEPS_W){1'b0}}, steps};

endmodule

### sv/dp_datapath.sv
// ----------------------------------------------------------------------------
// dp_datapath: value, BCD conversion and digit accumulation
// Converts the working value to decimal one bit per cycle (shift-add-3), then
// folds the digits into a sum or a product one digit per cycle.
// ----------------------------------------------------------------------------
module dp_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_pkg::cmd_t                cmd,
	output dp_pkg::sts_t                sts,
	input  logic                        in_kind,
	input  logic [dp_pkg::NUM_W-1:0]    in_number,
	output logic [dp_pkg::STEPS_W-1:0]  steps
);

	logic [dp_pkg::NUM_W-1:0]     value_q;
	logic                         kind_q;
	logic [dp_pkg::STEPS_W-1:0]   count_q;
	logic [dp_pkg::BIT_CNT_W-1:0] bitcnt_q;
	logic [dp_pkg::BCD_W-1:0]     bcd_q;
	logic [dp_pkg::NUM_W-1:0]     acc_q;
	logic [dp_pkg::STEPS_W-1:0]   steps_q;

	logic [dp_pkg::BCD_W-1:0]     bcd_adj;
	logic [dp_pkg::DIGIT_W-1:0]   digit;
	logic [dp_pkg::NUM_W-1:0]     acc_next;
	logic [dp_pkg::BCD_W-1:0]     bcd_rest;

	always_comb begin
		for (int i = 0; i < dp_pkg::DIGITS; i++) begin
			if (bcd_q[i*dp_pkg::DIGIT_W +: dp_pkg::DIGIT_W] >= dp_pkg::DD_THRESH) begin
				bcd_adj[i*dp_pkg::DIGIT_W +: dp_pkg::DIGIT_W] =
					bcd_q[i*dp_pkg::DIGIT_W +: dp_pkg::DIGIT_W] + dp_pkg::DD_ADJUST;
			end else begin
				bcd_adj[i*dp_pkg::DIGIT_W +: dp_pkg::DIGIT_W] =
					bcd_q[i*dp_pkg::DIGIT_W +: dp_pkg::DIGIT_W];
			end
		end
	end

	assign digit    = bcd_q[dp_pkg::DIGIT_W-1:0];
	assign bcd_rest = bcd_q >> dp_pkg::DIGIT_W;

	always_comb begin
		if (kind_q) begin
			acc_next = acc_q * {{(dp_pkg::NUM_W-dp_pkg::DIGIT_W){1'b0}}, digit};
		end else begin
			acc_next = acc_q + {{(dp_pkg::NUM_W-dp_pkg::DIGIT_W){1'b0}}, digit};
		end
	end

	// Digits are taken from the low end; once the remaining digits are all
	// zero they are leading zeros and take no part in the sum or product.
	assign sts.done      = (value_q < dp_pkg::RADIX) || (count_q == dp_pkg::STEPS_MAX);
	assign sts.conv_last = (bitcnt_q == {dp_pkg::BIT_CNT_W{1'b1}});
	assign sts.acc_last  = (bcd_rest == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_number;
			kind_q  <= in_kind;
		end else if (cmd.conv_step) begin
			value_q <= value_q << 1;
		end else if (cmd.acc_step && sts.acc_last) begin
			value_q <= acc_next;
		end

		if (cmd.start_conv) begin
			bcd_q <= '0;
			acc_q <= kind_q ? dp_pkg::NUM_W'(1) : '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[dp_pkg::BCD_W-2:0], value_q[dp_pkg::NUM_W-1]};
		end else if (cmd.acc_step) begin
			bcd_q <= bcd_rest;
			acc_q <= acc_next;
		end

		if (cmd.out_load) begin
			steps_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			bitcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
			end else if (cmd.acc_step && sts.acc_last) begin
				count_q <= count_q + 1'b1;
			end

			if (cmd.start_conv) begin
				bitcnt_q <= '0;
			end else if (cmd.conv_step) begin
				bitcnt_q <= bitcnt_q + 1'b1;
			end
		end
	end

	assign steps = steps_q;

endmodule

### sv/dp_ctrl.sv
// ----------------------------------------------------------------------------
// dp_ctrl: sequencer for the digit persistence block
// Steps through check, conversion and accumulation rounds and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module dp_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output dp_pkg::cmd_t cmd,
	input  dp_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CONV,
		ST_ACC,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load       = in_valid;
			ST_CHECK:  cmd.start_conv = !sts.done;
			ST_CONV:   cmd.conv_step  = 1'b1;
			ST_ACC:    cmd.acc_step   = 1'b1;
			ST_FINISH: cmd.out_load   = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= sts.done ? ST_FINISH : ST_CONV;
				end
				ST_CONV: begin
					if (sts.conv_last) state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (sts.acc_last) state_q <= ST_CHECK;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/dp_checker.sv
// ----------------------------------------------------------------------------
// dp_checker: port-level checks for the digit persistence block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [dp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// A stalled result word stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed or dropped while stalled");

	// The step count never exceeds four bits; the pad stays zero.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[dp_pkg::OUT_TDATA_W-1:dp_pkg::STEPS_W] == '0)
		else $error("result pad bits are not zero");

	// One word at a time: after an input word is taken, the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a word was accepted");

	// An accepted word always needs at least the check and finish cycles.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared in the cycle after an input word");

endmodule

bind digit_persistence dp_checker u_dp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/digit_persistence_test.sv
// ----------------------------------------------------------------------------
// digit_persistence_test: self-checking bench for digit_persistence
// Feeds a short table of edge values and then random numbers in both modes,
// with random gaps and backpressure, and compares every step count against
// the table's count or a decimal persistence calculation kept in the bench.
// ----------------------------------------------------------------------------
module digit_persistence_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_SUM     = 1'b0;
	localparam logic KIND_PRODUCT = 1'b1;

	localparam int RANDOM_WORDS     = 500;
	localparam int HOLD_START_CYCLE = 5000;
	localparam int HOLD_CYCLES      = 600;
	localparam int DRAIN_CYCLES     = 1000;

	typedef struct {
		logic                       kind;
		logic [dp_pkg::NUM_W-1:0]   number;
		bit                         known;
		logic [dp_pkg::STEPS_W-1:0] steps;
	} stim_row_t;

	typedef struct {
		bit                         known;
		logic [dp_pkg::STEPS_W-1:0] steps;
	} known_steps_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [dp_pkg::NUM_W-1:0]       s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [dp_pkg::OUT_TDATA_W-1:0] m_tdata;

	known_steps_t               offered_q[$];
	logic [dp_pkg::STEPS_W-1:0] pending_steps_q[$];
	int unsigned                failures = 0;

	// Rows with a known count carry it; the rest go through the calculation.
	stim_row_t directed_rows [18] = '{
		'{KIND_SUM,     64'd0,                    1'b1, 4'd0},
		'{KIND_PRODUCT, 64'd0,                    1'b1, 4'd0},
		'{KIND_SUM,     64'd9,                    1'b1, 4'd0},
		'{KIND_PRODUCT, 64'd9,                    1'b1, 4'd0},
		'{KIND_SUM,     64'd10,                   1'b1, 4'd1},
		'{KIND_PRODUCT, 64'd10,                   1'b1, 4'd1},
		'{KIND_SUM,     64'd18446744073709551615, 1'b1, 4'd3},
		'{KIND_PRODUCT, 64'd18446744073709551615, 1'b1, 4'd1},
		'{KIND_PRODUCT, 64'd277777788888899,      1'b1, 4'd11},
		'{KIND_SUM,     64'd199,                  1'b0, 4'd0},
		'{KIND_PRODUCT, 64'd77,                   1'b0, 4'd0},
		'{KIND_PRODUCT, 64'd25,                   1'b0, 4'd0},
		'{KIND_SUM,     64'd11,                   1'b0, 4'd0},
		'{KIND_PRODUCT, 64'd9999999999999999999,  1'b0, 4'd0},
		'{KIND_SUM,     64'd9999999999999999999,  1'b0, 4'd0},
		'{KIND_PRODUCT, 64'h8000_0000_0000_0000,  1'b0, 4'd0},
		'{KIND_SUM,     64'h5555_5555_5555_5555,  1'b0, 4'd0},
		'{KIND_PRODUCT, 64'hAAAA_AAAA_AAAA_AAAA,  1'b0, 4'd0}
	};

	digit_persistence uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [dp_pkg::STEPS_W-1:0] persistence_steps(input logic kind,
			input logic [dp_pkg::NUM_W-1:0] number);
		logic [dp_pkg::NUM_W-1:0]   value;
		logic [dp_pkg::NUM_W-1:0]   rest;
		logic [dp_pkg::NUM_W-1:0]   acc;
		logic [dp_pkg::STEPS_W-1:0] count;
		value = number;
		count = '0;
		while (value >= dp_pkg::RADIX && count != dp_pkg::STEPS_MAX) begin
			rest = value;
			// The value is at least ten here, so the product starts from one.
			acc = (kind == KIND_PRODUCT) ? dp_pkg::NUM_W'(1) : '0;
			while (rest != 0) begin
				if (kind == KIND_PRODUCT) begin
					acc = acc * (rest % dp_pkg::RADIX);
				end else begin
					acc = acc + (rest % dp_pkg::RADIX);
				end
				rest = rest / dp_pkg::RADIX;
			end
			value = acc;
			count = count + 1'b1;
		end
		return count;
	endfunction

	// Offers one word and returns at the edge where it is taken.
	task automatic offer_word(input logic kind, input logic [dp_pkg::NUM_W-1:0] number,
			input bit known, input logic [dp_pkg::STEPS_W-1:0] steps, input int gap);
		known_steps_t entry;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		entry.known = known;
		entry.steps = steps;
		offered_q.push_back(entry);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= number;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [dp_pkg::NUM_W-1:0] random_decimal(input int ndigits,
			input int low_digit);
		logic [dp_pkg::NUM_W-1:0] value;
		value = '0;
		for (int k = 0; k < ndigits; k++) begin
			value = value * dp_pkg::RADIX +
				dp_pkg::NUM_W'($urandom_range(9, low_digit));
		end
		return value;
	endfunction

	// Acceptance and checking share one process so the order within a step is fixed.
	always @(posedge clk) begin
		known_steps_t               entry;
		logic [dp_pkg::STEPS_W-1:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = persistence_steps(s_tuser, s_tdata);
				if (offered_q.size() != 0) begin
					entry = offered_q.pop_front();
					if (entry.known) begin
						want = entry.steps;
					end
				end
				pending_steps_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (pending_steps_q.size() == 0) begin
					$error("steps: no result expected, got %0d",
						m_tdata[dp_pkg::STEPS_W-1:0]);
					failures++;
				end else begin
					want = pending_steps_q.pop_front();
					if (m_tdata[dp_pkg::STEPS_W-1:0] !== want) begin
						$error("steps: expected %0d, got %0d", want,
							m_tdata[dp_pkg::STEPS_W-1:0]);
						failures++;
					end
					if (m_tdata[dp_pkg::OUT_TDATA_W-1:dp_pkg::STEPS_W] !== '0) begin
						$error("pad: expected 0, got %0h",
							m_tdata[dp_pkg::OUT_TDATA_W-1:dp_pkg::STEPS_W]);
						failures++;
					end
				end
			end
		end
	end

	// Result side: bursts of stall, one long hold to back the block up, and a
	// stretch that is always ready.
	initial begin
		int unsigned cycle;
		int          stall;
		m_tready = 1'b0;
		cycle = 0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle == HOLD_START_CYCLE) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cycle += HOLD_CYCLES;
				m_tready <= 1'b1;
			end else if (cycle > 8000 && cycle < 16000) begin
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(99, 0) < 2) begin
				stall = $urandom_range(20, 1);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic                     kind;
		logic [dp_pkg::NUM_W-1:0] number;
		int                       gap;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			gap = ($urandom_range(99, 0) < 20) ? $urandom_range(120, 1) : 0;
			offer_word(directed_rows[i].kind, directed_rows[i].number,
				directed_rows[i].known, directed_rows[i].steps, gap);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			kind = 1'($urandom_range(1, 0));
			case ($urandom_range(9, 0))
				0, 1, 2: number = {$urandom, $urandom};
				// Zero-free digit strings keep the product mode running many rounds.
				3, 4, 5, 6: number = random_decimal($urandom_range(19, 2),
					(kind == KIND_PRODUCT) ? 1 : 0);
				7: number = random_decimal($urandom_range(19, 2), 0);
				default: number = dp_pkg::NUM_W'($urandom_range(999, 0));
			endcase
			if (i >= 250 && i < 350) begin
				gap = 0;
			end else begin
				gap = ($urandom_range(99, 0) < 20) ? $urandom_range(120, 1) : 0;
			end
			offer_word(kind, number, 1'b0, '0, gap);
		end
		s_tvalid <= 1'b0;

		while (pending_steps_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
sv/dp_pkg.sv
sv/dp_datapath.sv
sv/dp_ctrl.sv
sv/digit_persistence.sv
sv/dp_checker.sv
tb/digit_persistence_test.sv
